// ===== hw/rtl/pcbl_pkg.sv =====
// Package for the pulse-count backlight level converter.
// Holds opcode, action and register codes, build constants and the threshold tables.
// No dependencies.
package pcbl_pkg;

	// Input opcodes. The fourth code is unused.
	localparam logic [1:0] OP_UPDATE  = 2'd0;
	localparam logic [1:0] OP_SUSPEND = 2'd1;
	localparam logic [1:0] OP_RESUME  = 2'd2;

	// Result actions.
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_OFF   = 2'd1;
	localparam logic [1:0] ACT_PULSE = 2'd2;

	// Register indexes on the APB port (byte address is four times the index).
	localparam logic [1:0] REG_MIN_BRIGHTNESS  = 2'd0;
	localparam logic [1:0] REG_DIMMING_LEVEL   = 2'd1;
	localparam logic [1:0] REG_FULL_BRIGHTNESS = 2'd2;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	// Register reset values and state reset values.
	localparam logic [7:0] MIN_BRIGHTNESS_RST  = 8'd20;
	localparam logic [4:0] DIMMING_LEVEL_RST   = 5'd31;
	localparam logic [7:0] FULL_BRIGHTNESS_RST = 8'd255;
	localparam logic [4:0] CHIP_LEVEL_RST      = 5'd10;

	// Table size of this build and the chip's ring length.
	localparam int BUILT_ENTRIES = 26;
	localparam int TABLE_ENTRIES = 26;
	localparam int RING_STEPS    = 32;

	// Entries actually searched: clamped to the built table, at least one.
	localparam int USED_ENTRIES = (TABLE_ENTRIES > BUILT_ENTRIES) ? BUILT_ENTRIES :
		((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);

	// Brightness thresholds and the chip levels that go with them.
	localparam logic [7:0] THR_TAB [BUILT_ENTRIES] = '{
		8'd20, 8'd30, 8'd41, 8'd52, 8'd63, 8'd74, 8'd85, 8'd96, 8'd107, 8'd118,
		8'd127, 8'd135, 8'd143, 8'd155, 8'd168, 8'd177, 8'd186, 8'd194, 8'd202,
		8'd210, 8'd218, 8'd226, 8'd234, 8'd241, 8'd248, 8'd255
	};
	localparam logic [4:0] LVL_TAB [BUILT_ENTRIES] = '{
		5'd31, 5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd23,
		5'd22, 5'd21, 5'd20, 5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13,
		5'd12, 5'd11, 5'd10, 5'd9, 5'd5, 5'd4, 5'd3
	};

endpackage

// ===== hw/rtl/pulse_count_backlight_level_top.sv =====
// Top level of the pulse-count backlight level converter.
// Uses pcbl_pkg for codes, constants and the threshold tables.
//
// Usage:
// The input channel (in_valid/in_ready) carries one beat per request: an
// opcode (update, suspend, resume then update), a brightness and display_on.
// The output channel (out_valid/out_ready) returns exactly one beat per
// request: the action, whether the enable rises first, the pulse count, the
// new chip level and the enable pin state.
// A beat is captured in an input register, the level is worked out by one
// parallel compare over the constant threshold table and one ring
// subtraction, and the result lands in the output register. One beat per
// cycle is sustained while the receiver takes every result; the output
// register is the only place a result waits. When the receiver stalls, the
// held result blocks the input register, which still takes one more beat;
// after that in_ready drops until out_ready. Reset leaves both channels
// empty, the chip level at 10, the block resumed and the registers at
// min_brightness 20, dimming_level 31, full_brightness 255. The user must
// write registers over APB only while idle; the block does not enforce it.
module pulse_count_backlight_level_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pcbl_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [pcbl_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [pcbl_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	// Request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          opcode,
	input  logic [7:0]                          brightness,
	input  logic                                display_on,
	// Result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          action,
	output logic                                enable_first,
	output logic [4:0]                          pulse_count,
	output logic [4:0]                          new_level,
	output logic                                pin_level
);
	import pcbl_pkg::*;

	// Configuration registers
	logic [7:0] min_brightness_q;
	logic [4:0] dimming_level_q;
	logic [7:0] full_brightness_q;

	// Block state
	logic [4:0] chip_level_q;
	logic       resumed_q;

	// Input stage
	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic [7:0] brightness_s1;
	logic       display_on_s1;

	// Output register
	logic       out_valid_q;
	logic [1:0] action_q;
	logic       enable_first_q;
	logic [4:0] pulse_count_q;
	logic [4:0] new_level_q;
	logic       pin_level_q;

	// Next-state logic
	logic       advance;
	logic       cfg_write;
	logic [1:0] cfg_index;
	logic [4:0] target;
	logic       resumed_eff;
	logic [7:0] ring_sum;
	logic [7:0] ring_diff;
	logic [1:0] action_d;
	logic       enable_first_d;
	logic [4:0] pulse_count_d;
	logic [4:0] level_d;
	logic       resumed_d;

	// Handshakes: the input stage moves on whenever the output register is free.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign cfg_write = psel && penable && pwrite;
	assign cfg_index = paddr[3:2];
	assign pready    = 1'b1;

	// Register read-back.
	always_comb begin
		prdata = '0;
		unique case (cfg_index)
			REG_MIN_BRIGHTNESS:  prdata = {{(CFG_DATA_W-8){1'b0}}, min_brightness_q};
			REG_DIMMING_LEVEL:   prdata = {{(CFG_DATA_W-5){1'b0}}, dimming_level_q};
			REG_FULL_BRIGHTNESS: prdata = {{(CFG_DATA_W-8){1'b0}}, full_brightness_q};
			default:             prdata = '0;
		endcase
	end

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_brightness_q  <= MIN_BRIGHTNESS_RST;
			dimming_level_q   <= DIMMING_LEVEL_RST;
			full_brightness_q <= FULL_BRIGHTNESS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MIN_BRIGHTNESS:  min_brightness_q  <= pwdata[7:0];
				REG_DIMMING_LEVEL:   dimming_level_q   <= pwdata[4:0];
				REG_FULL_BRIGHTNESS: full_brightness_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Target: blanking, low and full brightness first, then the table search.
	// The search runs from the top entry down so the lowest match wins.
	always_comb begin
		target = '0;
		if (!display_on_s1 || brightness_s1 == 8'd0) begin
			target = '0;
		end else if (brightness_s1 < min_brightness_q) begin
			target = dimming_level_q;
		end else if (brightness_s1 == full_brightness_q) begin
			target = LVL_TAB[USED_ENTRIES-1];
		end else begin
			for (int i = USED_ENTRIES - 1; i >= 0; i--) begin
				if (brightness_s1 <= THR_TAB[i]) begin
					target = LVL_TAB[i];
				end
			end
		end
	end

	// Forward steps around the chip's ring from the present level to the target.
	assign ring_sum  = {3'b000, target} + 8'(RING_STEPS)
		- 8'({3'b000, chip_level_q} % RING_STEPS);
	assign ring_diff = 8'(ring_sum % RING_STEPS);

	// Result and next state for the beat in the input stage.
	always_comb begin
		action_d       = ACT_NONE;
		enable_first_d = 1'b0;
		pulse_count_d  = '0;
		level_d        = chip_level_q;
		resumed_d      = resumed_q;
		resumed_eff    = (opcode_s1 == OP_RESUME) ? 1'b1 : resumed_q;
		unique case (opcode_s1)
			OP_SUSPEND: begin
				resumed_d = 1'b0;
				level_d   = '0;
				action_d  = ACT_OFF;
			end
			OP_UPDATE, OP_RESUME: begin
				resumed_d = resumed_eff;
				if (!resumed_eff || target == chip_level_q) begin
					action_d = ACT_NONE;
				end else if (target == 5'd0) begin
					level_d  = '0;
					action_d = ACT_OFF;
				end else if (ring_diff != 8'd0) begin
					level_d        = target;
					action_d       = ACT_PULSE;
					enable_first_d = (chip_level_q == 5'd0);
					pulse_count_d  = (ring_diff > 8'd31) ? 5'd31 : ring_diff[4:0];
				end
			end
			default: begin
				action_d = ACT_NONE;
			end
		endcase
	end

	// Input stage capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1     <= opcode;
			brightness_s1 <= brightness;
			display_on_s1 <= display_on;
		end
	end

	// Block state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_level_q <= CHIP_LEVEL_RST;
			resumed_q    <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				chip_level_q <= level_d;
				resumed_q    <= resumed_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			action_q       <= action_d;
			enable_first_q <= enable_first_d;
			pulse_count_q  <= pulse_count_d;
			new_level_q    <= level_d;
			pin_level_q    <= (level_d != 5'd0);
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign enable_first = enable_first_q;
	assign pulse_count  = pulse_count_q;
	assign new_level    = new_level_q;
	assign pin_level    = pin_level_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for the pulse-count backlight level converter.
// Needs pcbl_pkg and pulse_count_backlight_level_top; holds its own level predictor.
// Runs six register settings with random sender idling and receiver stalls.
`timescale 1ns / 100ps

module tb_top;
	import pcbl_pkg::*;

	// The fourth opcode has no use and must be ignored by the block.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int N_STEPS   = 26;
	localparam int RING_LEN  = 32;
	localparam int CYCLE_CAP = 200000;
	localparam int PRINT_CAP = 30;

	// Brightness thresholds and chip levels of the default build.
	localparam logic [7:0] LEVEL_THRESH [N_STEPS] = '{
		8'd20, 8'd30, 8'd41, 8'd52, 8'd63, 8'd74, 8'd85, 8'd96, 8'd107, 8'd118,
		8'd127, 8'd135, 8'd143, 8'd155, 8'd168, 8'd177, 8'd186, 8'd194, 8'd202,
		8'd210, 8'd218, 8'd226, 8'd234, 8'd241, 8'd248, 8'd255
	};
	localparam logic [4:0] LEVEL_CODE [N_STEPS] = '{
		5'd31, 5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd23,
		5'd22, 5'd21, 5'd20, 5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13,
		5'd12, 5'd11, 5'd10, 5'd9, 5'd5, 5'd4, 5'd3
	};

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] bright;
		logic       on;
	} request_t;

	typedef struct packed {
		logic [1:0] act;
		logic       en_first;
		logic [4:0] pulses;
		logic [4:0] lvl;
		logic       pin;
	} level_result_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] opcode = OP_UPDATE;
	logic [7:0] brightness = '0;
	logic       display_on = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] action;
	logic       enable_first;
	logic [4:0] pulse_count;
	logic [4:0] new_level;
	logic       pin_level;

	// Register mirror and predicted chip state.
	logic [7:0] cfg_min = MIN_BRIGHTNESS_RST;
	logic [4:0] cfg_dim = DIMMING_LEVEL_RST;
	logic [7:0] cfg_full = FULL_BRIGHTNESS_RST;
	logic [4:0] chip_lvl = CHIP_LEVEL_RST;
	logic       is_resumed = 1'b1;

	request_t      request_q[$];
	level_result_t level_q[$];
	int open_items = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic in_taken = 1'b0;
	int cycle_cnt = 0;
	int err_cnt = 0;
	int result_cnt = 0;
	int n_pulse = 0;
	int n_off = 0;
	int n_none = 0;

	pulse_count_backlight_level_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.brightness(brightness),
		.display_on(display_on),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.action(action),
		.enable_first(enable_first),
		.pulse_count(pulse_count),
		.new_level(new_level),
		.pin_level(pin_level)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Chip level that a brightness asks for under the present registers.
	function automatic logic [4:0] pick_target(logic [7:0] b, logic on);
		if (!on || b == 8'd0) return 5'd0;
		if (b < cfg_min) return cfg_dim;
		if (b == cfg_full) return LEVEL_CODE[N_STEPS-1];
		for (int i = 0; i < N_STEPS; i++) begin
			if (b <= LEVEL_THRESH[i]) return LEVEL_CODE[i];
		end
		return 5'd0;
	endfunction

	// Advances the predicted chip state by one request and returns its result.
	function automatic level_result_t predict_level(request_t rq);
		level_result_t res;
		logic [4:0] target;
		int steps;
		res = '0;
		case (rq.op)
			OP_SUSPEND: begin
				is_resumed = 1'b0;
				chip_lvl = 5'd0;
				res.act = ACT_OFF;
			end
			OP_UPDATE, OP_RESUME: begin
				if (rq.op == OP_RESUME) is_resumed = 1'b1;
				target = pick_target(rq.bright, rq.on);
				if (is_resumed && target != chip_lvl) begin
					if (target == 5'd0) begin
						chip_lvl = 5'd0;
						res.act = ACT_OFF;
					end else begin
						steps = (int'(target) + RING_LEN - int'(chip_lvl) % RING_LEN) % RING_LEN;
						if (steps > 31) steps = 31;
						if (steps != 0) begin
							res.act = ACT_PULSE;
							res.en_first = (chip_lvl == 5'd0);
							res.pulses = 5'(steps);
							chip_lvl = target;
						end
					end
				end
			end
			default: begin
			end
		endcase
		res.lvl = chip_lvl;
		res.pin = (chip_lvl != 5'd0);
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (err_cnt < PRINT_CAP)
			$display("%0t: result %0d: %s is %0d, expected %0d", $realtime, result_cnt, what,
				got, want);
		err_cnt++;
	endtask

	// Compares one result beat field by field with the oldest expectation.
	task automatic check_result();
		level_result_t want;
		if (level_q.size() == 0) begin
			report_mismatch("action of a result with nothing pending", action, 0);
		end else begin
			want = level_q.pop_front();
			if (action !== want.act) report_mismatch("action", action, want.act);
			if (enable_first !== want.en_first)
				report_mismatch("enable_first", enable_first, want.en_first);
			if (pulse_count !== want.pulses) report_mismatch("pulse_count", pulse_count, want.pulses);
			if (new_level !== want.lvl) report_mismatch("new_level", new_level, want.lvl);
			if (pin_level !== want.pin) report_mismatch("pin_level", pin_level, want.pin);
			case (want.act)
				ACT_PULSE: n_pulse++;
				ACT_OFF:   n_off++;
				default:   n_none++;
			endcase
			open_items--;
		end
		result_cnt++;
	endtask

	// Driver: presents the next pending request at the falling edge, holding a beat
	// until it has been taken, and draws out_ready at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || in_taken) begin
				if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					request_t rq;
					rq = request_q.pop_front();
					in_valid <= 1'b1;
					opcode <= rq.op;
					brightness <= rq.bright;
					display_on <= rq.on;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predicts on every accepted request and checks every accepted result.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				level_q.push_back(predict_level('{op: opcode, bright: brightness, on: display_on}));
			if (out_valid && out_ready) check_result();
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_CAP) begin
			$display("%0t: no progress after %0d cycles", $realtime, cycle_cnt);
			$display("[pulse_count_backlight_level_top] ERROR");
			$finish;
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MIN_BRIGHTNESS:  cfg_min = val[7:0];
			REG_DIMMING_LEVEL:   cfg_dim = val[4:0];
			REG_FULL_BRIGHTNESS: cfg_full = val[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic push_request(logic [1:0] op, logic [7:0] b, logic on);
		request_q.push_back('{op: op, bright: b, on: on});
		open_items++;
	endtask

	// Waits until every queued request has produced its result.
	task automatic wait_drained();
		while (open_items != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Brightness biased toward table thresholds and the two register boundaries.
	function automatic logic [7:0] rand_brightness();
		int pick;
		int base;
		pick = $urandom_range(9);
		if (pick < 5) return 8'($urandom_range(255));
		if (pick < 8) base = LEVEL_THRESH[$urandom_range(N_STEPS-1)];
		else if (pick == 8) base = cfg_min;
		else base = cfg_full;
		base = base + int'($urandom_range(2)) - 1;
		if (base < 0) base = 0;
		if (base > 255) base = 255;
		return 8'(base);
	endfunction

	task automatic push_random(int count);
		int r;
		logic [1:0] op;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 5) op = OP_SUSPEND;
			else if (r < 17) op = OP_RESUME;
			else if (r < 20) op = OP_UNUSED;
			else op = OP_UPDATE;
			push_request(op, rand_brightness(), $urandom_range(9) != 0);
		end
	endtask

	// Stimulus: six register settings and idling modes, the first with a directed set.
	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			case (p)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					apb_write(REG_MIN_BRIGHTNESS, 32'(MIN_BRIGHTNESS_RST));
					apb_write(REG_DIMMING_LEVEL, 32'(DIMMING_LEVEL_RST));
					apb_write(REG_FULL_BRIGHTNESS, 32'(FULL_BRIGHTNESS_RST));
				end
				1: begin
					send_idle_pct = 63;
					recv_stall_pct = 0;
					apb_write(REG_MIN_BRIGHTNESS, 32'd0);
					apb_write(REG_DIMMING_LEVEL, 32'd1);
					apb_write(REG_FULL_BRIGHTNESS, 32'd0);
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 63;
					apb_write(REG_MIN_BRIGHTNESS, 32'd255);
					apb_write(REG_DIMMING_LEVEL, 32'd31);
					apb_write(REG_FULL_BRIGHTNESS, 32'd255);
				end
				3: begin
					send_idle_pct = 23;
					recv_stall_pct = 23;
					apb_write(REG_MIN_BRIGHTNESS, 32'd100);
					apb_write(REG_DIMMING_LEVEL, 32'd16);
					apb_write(REG_FULL_BRIGHTNESS, 32'd143);
				end
				4: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					apb_write(REG_MIN_BRIGHTNESS, 32'($urandom_range(255)));
					apb_write(REG_DIMMING_LEVEL, 32'($urandom_range(31, 1)));
					apb_write(REG_FULL_BRIGHTNESS, 32'($urandom_range(255)));
				end
				default: begin
					send_idle_pct = 23;
					recv_stall_pct = 23;
					apb_write(REG_MIN_BRIGHTNESS, 32'd20);
					apb_write(REG_DIMMING_LEVEL, 32'd31);
					apb_write(REG_FULL_BRIGHTNESS, 32'd200);
				end
			endcase
			if (p == 0) begin
				// Full brightness from the boot level, then the same level again.
				push_request(OP_UPDATE, 8'd255, 1'b1);
				push_request(OP_UPDATE, 8'd255, 1'b1);
				// Zero brightness, then dimming level with the enable rising first.
				push_request(OP_UPDATE, 8'd0, 1'b1);
				push_request(OP_UPDATE, 8'd1, 1'b1);
				push_request(OP_UPDATE, 8'd19, 1'b1);
				push_request(OP_UPDATE, 8'd20, 1'b1);
				push_request(OP_UPDATE, 8'd31, 1'b1);
				push_request(OP_UPDATE, 8'd143, 1'b1);
				push_request(OP_UPDATE, 8'd144, 1'b1);
				// Blanked display forces the chip off.
				push_request(OP_UPDATE, 8'd200, 1'b0);
				push_request(OP_UPDATE, 8'd128, 1'b1);
				// Suspend twice, an update while suspended, the unused opcode.
				push_request(OP_SUSPEND, 8'd128, 1'b1);
				push_request(OP_SUSPEND, 8'd0, 1'b0);
				push_request(OP_UPDATE, 8'd100, 1'b1);
				push_request(OP_UNUSED, 8'd255, 1'b1);
				// Resume into a level, into off, and into the level already held.
				push_request(OP_RESUME, 8'd254, 1'b1);
				push_request(OP_RESUME, 8'd0, 1'b1);
				push_request(OP_RESUME, 8'd254, 1'b0);
				push_request(OP_UPDATE, 8'd127, 1'b1);
				push_request(OP_UPDATE, 8'd241, 1'b1);
				push_request(OP_UPDATE, 8'd242, 1'b1);
				push_request(OP_UPDATE, 8'd9, 1'b1);
				push_request(OP_UNUSED, 8'd0, 1'b0);
				push_request(OP_UPDATE, 8'd170, 1'b1);
				push_request(OP_SUSPEND, 8'd255, 1'b1);
			end
			if (p == 3) begin
				// Sender holds off until the block has emptied, then resumes.
				push_random(85);
				wait_drained();
				push_random(86);
			end else begin
				push_random(171);
			end
		end
		wait_drained();
		repeat (10) @(negedge clk);
		if (level_q.size() != 0)
			report_mismatch("results still missing at the end", 0, level_q.size());
		$display("Checked %0d results over six register settings and four idling modes.",
			result_cnt);
		$display("Results: %0d pulse steps, %0d switch-offs, %0d with no change.",
			n_pulse, n_off, n_none);
		if (err_cnt == 0) begin
			$display("[pulse_count_backlight_level_top] OK");
		end else begin
			$display("%0d mismatches found", err_cnt);
			$display("[pulse_count_backlight_level_top] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/pcbl_pkg.sv
hw/rtl/pulse_count_backlight_level_top.sv
verif/tb_top.sv
